// File: design/bmp24sd_pkg.sv
// Shared types, constants and the header field check for the BMP24 stream decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package bmp24sd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Dimension registers hold the maximum itself
    localparam int W_DIM = $clog2(MAX_WIDTH + 1);
    localparam int H_DIM = $clog2(MAX_HEIGHT + 1);

    localparam int COORD_W = 12;
    localparam int IDX_W   = 6;

    // Header byte index at which each checked field is complete
    localparam logic [IDX_W-1:0] IDX_SIGNATURE   = 6'd1;
    localparam logic [IDX_W-1:0] IDX_INFO_LEN    = 6'd17;
    localparam logic [IDX_W-1:0] IDX_WIDTH       = 6'd21;
    localparam logic [IDX_W-1:0] IDX_HEIGHT      = 6'd25;
    localparam logic [IDX_W-1:0] IDX_PLANES      = 6'd27;
    localparam logic [IDX_W-1:0] IDX_BPP         = 6'd29;
    localparam logic [IDX_W-1:0] IDX_COMPRESSION = 6'd33;
    localparam logic [IDX_W-1:0] IDX_COLORS_USED = 6'd49;
    localparam logic [IDX_W-1:0] IDX_HDR_LAST    = 6'd53;

    localparam logic [15:0] SIGNATURE_BM = 16'h4d42;
    localparam logic [31:0] HDR_INFO_LEN = 32'd40;
    localparam logic [15:0] NUM_PLANES   = 16'd1;
    localparam logic [15:0] BITS_PER_PX  = 16'd24;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_HEADER,
        MODE_PIXELS,
        MODE_DONE
    } t_mode;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last;
    } t_result;

    // v holds the last four header bytes, newest in the top byte
    function automatic logic field_ok(input logic [IDX_W-1:0] idx, input logic [31:0] v);
        logic ok;
        ok = 1'b1;
        case (idx)
            IDX_SIGNATURE:   ok = (v[31:16] == SIGNATURE_BM);
            IDX_INFO_LEN:    ok = (v == HDR_INFO_LEN);
            IDX_WIDTH:       ok = !v[31] && (v != 32'd0) && (v <= 32'(MAX_WIDTH));
            IDX_HEIGHT:      ok = !v[31] && (v != 32'd0) && (v <= 32'(MAX_HEIGHT));
            IDX_PLANES:      ok = (v[31:16] == NUM_PLANES);
            IDX_BPP:         ok = (v[31:16] == BITS_PER_PX);
            IDX_COMPRESSION: ok = (v == 32'd0);
            IDX_COLORS_USED: ok = (v == 32'd0);
            default:         ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: design/bmp24_stream_decoder_core.sv
// An accepted byte is held in the input register; its result, if any, is then loaded into the result register.
// Throughput: one byte per cycle while the result register is not stalled, set by the single parser update per byte.
// Reset (synchronous, active low) empties both registers and leaves the parser
// idle, ignoring bytes until one arrives with the start flag.
// Top level of the BMP24 stream decoder: input register, parser, result register.
// Depends on bmp24sd_pkg, bmp24sd_parser and bmp24sd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module bmp24_stream_decoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tuser,   // [0] start_of_file
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // [11:0] pixel_x, [23:12] pixel_y, [31:24] red,
                                     // [39:32] green, [47:40] blue
    output logic        o_m_tuser,   // [0] kind
    output logic        o_m_tlast    // last
);
    import bmp24sd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sof;
    logic       out_free;
    logic       consume;
    logic       in_xfer;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign out_free   = !o_m_tvalid || i_m_tready;
    assign consume    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_tdata;
            r_in_sof  <= i_s_tuser;
        end
    end

    bmp24sd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (consume),
        .i_byte      (r_in_byte),
        .i_sof       (r_in_sof),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bmp24sd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume && res_valid),
        .i_res   (res),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (out_res)
    );

    assign o_m_tdata = {out_res.blue, out_res.green, out_res.red,
                        out_res.pixel_y, out_res.pixel_x};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last;

endmodule

`default_nettype wire

// File: design/bmp24sd_parser.sv
// Header parse and check plus pixel assembly: one byte per enable.
// Depends on bmp24sd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp24sd_parser (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire [7:0]             i_byte,
    input  wire                   i_sof,
    output logic                  o_res_valid,
    output bmp24sd_pkg::t_result  o_res
);
    import bmp24sd_pkg::*;

    t_mode            r_mode, n_mode, e_mode;
    logic [IDX_W-1:0] r_idx, n_idx, e_idx;
    logic [31:0]      r_asm, n_asm, e_asm;
    logic             r_hvalid, n_hvalid, e_hvalid;
    logic [W_DIM-1:0] r_width, n_width, e_width;
    logic [H_DIM-1:0] r_height, n_height, e_height;
    logic [W_DIM-1:0] r_col, n_col, e_col;
    logic [H_DIM-1:0] r_row, n_row, e_row;
    logic [1:0]       r_comp, n_comp, e_comp;
    logic [1:0]       r_pad, n_pad, e_pad;
    logic [7:0]       r_blue, n_blue, e_blue;
    logic [7:0]       r_green, n_green, e_green;

    logic [31:0]      asm_shift;
    logic             fld_ok;
    logic             hdr_done;
    logic [W_DIM-1:0] col_inc;
    logic [H_DIM-1:0] row_inc;
    logic [H_DIM-1:0] y_full;
    logic             row_end;
    logic             img_end;
    logic             px_emit;

    // A start restarts parsing before this byte is taken
    always_comb begin
        e_mode   = r_mode;
        e_idx    = r_idx;
        e_asm    = r_asm;
        e_hvalid = r_hvalid;
        e_width  = r_width;
        e_height = r_height;
        e_col    = r_col;
        e_row    = r_row;
        e_comp   = r_comp;
        e_pad    = r_pad;
        e_blue   = r_blue;
        e_green  = r_green;
        if (i_sof) begin
            e_mode   = MODE_HEADER;
            e_idx    = '0;
            e_asm    = '0;
            e_hvalid = 1'b1;
            e_width  = '0;
            e_height = '0;
            e_col    = '0;
            e_row    = '0;
            e_comp   = '0;
            e_pad    = '0;
            e_blue   = '0;
            e_green  = '0;
        end
    end

    assign asm_shift = {i_byte, e_asm[31:8]};
    assign fld_ok    = field_ok(e_idx, asm_shift);
    assign hdr_done  = (e_idx >= IDX_HDR_LAST);
    assign col_inc   = e_col + 1'b1;
    assign row_inc   = e_row + 1'b1;
    assign y_full    = e_height - 1'b1 - e_row;
    assign row_end   = (col_inc >= e_width);
    assign img_end   = row_end && (row_inc >= e_height);
    assign px_emit   = (e_mode == MODE_PIXELS) && (e_pad == 2'd0) && (e_comp == 2'd2);

    // Next state
    always_comb begin
        n_mode = e_mode;
        unique case (e_mode)
            MODE_IDLE:   n_mode = MODE_IDLE;
            MODE_HEADER: begin
                if (hdr_done) begin
                    n_mode = (e_hvalid && fld_ok) ? MODE_PIXELS : MODE_DONE;
                end
            end
            MODE_PIXELS: begin
                if (px_emit && img_end) begin
                    n_mode = MODE_DONE;
                end
            end
            MODE_DONE:   n_mode = MODE_DONE;
            default:     n_mode = MODE_IDLE;
        endcase
    end

    // Datapath and result
    always_comb begin
        n_idx    = e_idx;
        n_asm    = e_asm;
        n_hvalid = e_hvalid;
        n_width  = e_width;
        n_height = e_height;
        n_col    = e_col;
        n_row    = e_row;
        n_comp   = e_comp;
        n_pad    = e_pad;
        n_blue   = e_blue;
        n_green  = e_green;
        o_res_valid   = 1'b0;
        o_res.kind    = KIND_PIXEL;
        o_res.pixel_x = COORD_W'(e_col);
        o_res.pixel_y = COORD_W'(y_full);
        o_res.red     = i_byte;
        o_res.green   = e_green;
        o_res.blue    = e_blue;
        o_res.last    = 1'b0;
        unique case (e_mode)
            MODE_HEADER: begin
                n_asm    = asm_shift;
                n_hvalid = e_hvalid && fld_ok;
                if (fld_ok && (e_idx == IDX_WIDTH)) begin
                    n_width = W_DIM'(asm_shift);
                end
                if (fld_ok && (e_idx == IDX_HEIGHT)) begin
                    n_height = H_DIM'(asm_shift);
                end
                if (hdr_done) begin
                    if (!(e_hvalid && fld_ok)) begin
                        o_res_valid   = 1'b1;
                        o_res         = '0;
                        o_res.kind    = KIND_ERROR;
                        o_res.last    = 1'b1;
                    end
                end else begin
                    n_idx = e_idx + 1'b1;
                end
            end
            MODE_PIXELS: begin
                if (e_pad != 2'd0) begin
                    n_pad = e_pad - 1'b1;
                end else if (e_comp == 2'd0) begin
                    n_blue = i_byte;
                    n_comp = 2'd1;
                end else if (e_comp == 2'd1) begin
                    n_green = i_byte;
                    n_comp  = 2'd2;
                end else begin
                    n_comp      = 2'd0;
                    o_res_valid = 1'b1;
                    o_res.last  = img_end;
                    n_col       = row_end ? '0 : col_inc;
                    if (row_end && !img_end) begin
                        n_row = row_inc;
                        // 3*width bytes per row: pad count equals width mod 4
                        n_pad = e_width[1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_idx    <= '0;
            r_asm    <= '0;
            r_hvalid <= 1'b1;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_comp   <= '0;
            r_pad    <= '0;
            r_blue   <= '0;
            r_green  <= '0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_idx    <= n_idx;
            r_asm    <= n_asm;
            r_hvalid <= n_hvalid;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_comp   <= n_comp;
            r_pad    <= n_pad;
            r_blue   <= n_blue;
            r_green  <= n_green;
        end
    end

endmodule

`default_nettype wire

// File: design/bmp24sd_out_reg.sv
// Result register holding one decoded item until the downstream side takes it.
// Depends on bmp24sd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp24sd_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  bmp24sd_pkg::t_result  i_res,
    input  wire                   i_ready,
    output logic                  o_valid,
    output bmp24sd_pkg::t_result  o_res
);
    import bmp24sd_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: design/bmp24sd_checker.sv
// Port-level checks for the BMP24 stream decoder, bound to the top level.
// Depends on bmp24sd_pkg and bmp24_stream_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

module bmp24sd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [47:0] o_m_tdata,
    input wire        o_m_tuser,
    input wire        o_m_tlast
);
    import bmp24sd_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // Error result is a zeroed, final transfer
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_ERROR) |-> o_m_tlast && (o_m_tdata == 48'd0))
        else $error("malformed error result");

    // Input side never blocks while the result slot is empty
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // Reset leaves no pending result
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

endmodule

bind bmp24_stream_decoder_core bmp24sd_checker u_bmp24sd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
